FILE: rtl/lep_pkg.sv
// Shared constants, types and the coefficient ROM for the Legendre evaluator.
// No dependencies; the CORDIC, multiplier, top level and checker refer to it by scoped names.
package lep_pkg;

   localparam int LMAX         = 16;
   localparam int ROW          = LMAX + 1;
   localparam int ROM_DEPTH    = ROW * ROW;
   localparam int ROM_AW       = $clog2(ROM_DEPTH);
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int COEF_W       = 40;
   localparam int ACC_W        = 48;
   localparam int PROD_W       = 49;
   localparam int TRIG_W       = 32;
   localparam int CZ_W         = 34;
   localparam int VALUE_W      = 23;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DEGREE  = 2'd1;
   localparam logic [1:0] STATUS_P1_ZERO = 2'd2;

   localparam logic signed [ACC_W-1:0] ACC_LIMIT  = 48'sd140737488355327;
   localparam logic signed [CZ_W-1:0]  CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CZ_W-1:0]  ONE_Q30     = 34'sd1073741824;
   localparam logic signed [16:0]      PI_Q13      = 17'sd25736;
   localparam logic signed [16:0]      HALF_PI_Q13 = 17'sd12868;
   localparam logic [127:0]            COEF_LIMIT  = 128'd549755813887;

   typedef logic signed [COEF_W-1:0] coef_rom_type [ROM_DEPTH];
   typedef logic signed [CZ_W-1:0]   atan_tab_type [CORDIC_STEPS];

   localparam atan_tab_type ATAN_TAB = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768
   };

   // Binomial coefficient by Pascal's rule (elaboration only)
   function automatic logic [63:0] binom(input int a, input int b);
      logic [63:0] row [65];
      for (int j = 0; j < 65; j++) row[j] = '0;
      row[0] = 64'd1;
      if (a > 64 || b > a || b < 0) return '0;
      for (int r = 1; r <= a; r++)
         for (int j = r; j >= 1; j--) row[j] = row[j] + row[j-1];
      return row[b];
   endfunction

   // c(n,n-2m) = (-1)^m C(n,m) C(2n-2m,n) / 2^n in Q24, saturated
   function automatic logic signed [COEF_W-1:0] make_coef(input int n, input int m);
      logic [127:0] mag;
      logic [127:0] c1;
      logic [127:0] c2;
      c1  = {64'd0, binom(n, m)};
      c2  = {64'd0, binom(2*n - 2*m, n)};
      mag = (c1 * c2) << (24 - n);
      if (mag > COEF_LIMIT) mag = COEF_LIMIT;
      if (m % 2 == 1) return -$signed(COEF_W'(mag));
      return $signed(COEF_W'(mag));
   endfunction

   function automatic coef_rom_type build_coef_rom();
      coef_rom_type rom;
      for (int i = 0; i < ROM_DEPTH; i++) rom[i] = '0;
      for (int n = 0; n <= LMAX; n++)
         for (int m = 0; m <= n / 2; m++)
            rom[n*ROW + n - 2*m] = make_coef(n, m);
      return rom;
   endfunction

   localparam coef_rom_type COEF_ROM = build_coef_rom();

   // Clamp a widened sum to the accumulator range
   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
      if (v > $signed({{2{ACC_LIMIT[ACC_W-1]}}, ACC_LIMIT})) return ACC_LIMIT;
      if (v < -$signed({{2{ACC_LIMIT[ACC_W-1]}}, ACC_LIMIT})) return -ACC_LIMIT;
      return v[ACC_W-1:0];
   endfunction

endpackage

FILE: rtl/lep_ifs.sv
// Request and response channel interfaces for the Legendre evaluator.
// Depends on nothing; payload widths are fixed by the channel format.
interface lep_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic [4:0]        degree;
   logic signed [15:0] angle;
   modport source (output valid, func, degree, angle, input ready);
   modport sink   (input valid, func, degree, angle, output ready);
endinterface

interface lep_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [22:0] value;
   logic [1:0]         status;
   modport source (output valid, value, status, input ready);
   modport sink   (input valid, value, status, output ready);
endinterface

FILE: rtl/lep_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 out.
// Depends on lep_pkg for the arctangent table and widths.
module lep_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [15:0]                angle,
   output logic                              done,
   output logic signed [lep_pkg::TRIG_W-1:0] cos_out,
   output logic signed [lep_pkg::TRIG_W-1:0] sin_out
);
   logic signed [lep_pkg::CZ_W-1:0]   x_ff, y_ff, z_ff;
   logic [lep_pkg::STEP_W-1:0]        step_ff;
   logic                              busy_ff, flip_ff, done_ff;
   logic signed [lep_pkg::TRIG_W-1:0] cos_ff, sin_ff;
   logic signed [16:0]                ang_ext, ang_fold;
   logic                              flip_in;
   logic signed [lep_pkg::CZ_W-1:0]   x_sh, y_sh, x_cl, y_cl;

   // Fold into +-pi/2
   always_comb begin
      ang_ext = 17'(angle);
      flip_in = 1'b0;
      ang_fold = ang_ext;
      if (ang_ext > lep_pkg::HALF_PI_Q13) begin
         ang_fold = ang_ext - lep_pkg::PI_Q13;
         flip_in  = 1'b1;
      end else if (ang_ext < -lep_pkg::HALF_PI_Q13) begin
         ang_fold = ang_ext + lep_pkg::PI_Q13;
         flip_in  = 1'b1;
      end
   end

   assign x_sh = x_ff >>> step_ff;
   assign y_sh = y_ff >>> step_ff;

   // Clamp to +-1.0
   always_comb begin
      x_cl = x_ff;
      y_cl = y_ff;
      if (x_ff > lep_pkg::ONE_Q30) x_cl = lep_pkg::ONE_Q30;
      if (x_ff < -lep_pkg::ONE_Q30) x_cl = -lep_pkg::ONE_Q30;
      if (y_ff > lep_pkg::ONE_Q30) y_cl = lep_pkg::ONE_Q30;
      if (y_ff < -lep_pkg::ONE_Q30) y_cl = -lep_pkg::ONE_Q30;
   end

   // Advance one micro-rotation per cycle
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
         flip_ff <= flip_in;
         x_ff    <= lep_pkg::CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= {ang_fold, 17'd0};
      end else if (busy_ff) begin
         if (!z_ff[lep_pkg::CZ_W-1]) begin
            x_ff <= x_ff - y_sh;
            y_ff <= y_ff + x_sh;
            z_ff <= z_ff - lep_pkg::ATAN_TAB[step_ff];
         end else begin
            x_ff <= x_ff + y_sh;
            y_ff <= y_ff - x_sh;
            z_ff <= z_ff + lep_pkg::ATAN_TAB[step_ff];
         end
         // Hold the last step index so the finish cycle can see it
         if (step_ff == lep_pkg::STEP_W'(lep_pkg::CORDIC_STEPS - 1)) busy_ff <= 1'b0;
         else step_ff <= step_ff + 1'b1;
      end else if (step_ff == lep_pkg::STEP_W'(lep_pkg::CORDIC_STEPS - 1)) begin
         // Clamp and unfold the finished pair
         step_ff <= '0;
         done_ff <= 1'b1;
         cos_ff  <= flip_ff ? -lep_pkg::TRIG_W'(x_cl) : lep_pkg::TRIG_W'(x_cl);
         sin_ff  <= flip_ff ? -lep_pkg::TRIG_W'(y_cl) : lep_pkg::TRIG_W'(y_cl);
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;
endmodule

FILE: rtl/lep_mul.sv
// Sign-magnitude multiplier: round(a*b / 2^30), |b| clamped to 1.0.
// Depends on lep_pkg for widths.
module lep_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [lep_pkg::ACC_W-1:0]  a,
   input  logic signed [lep_pkg::TRIG_W-1:0] b,
   output logic                              done,
   output logic signed [lep_pkg::PROD_W-1:0] prod
);
   logic [lep_pkg::ACC_W-1:0]        ma_ff;
   logic [30:0]                      mb_ff;
   logic                             neg_ff, ph1_ff, ph2_ff, done_ff;
   logic [62:0]                      hi_ff;
   logic signed [lep_pkg::PROD_W-1:0] prod_ff;
   logic [lep_pkg::ACC_W-1:0]        ma_in;
   logic [lep_pkg::TRIG_W-1:0]       mb_abs;
   logic [30:0]                      mb_in;
   logic [79:0]                      sum;

   // Magnitudes of the operands
   always_comb begin
      ma_in  = a[lep_pkg::ACC_W-1] ? lep_pkg::ACC_W'(-a) : lep_pkg::ACC_W'(a);
      mb_abs = b[lep_pkg::TRIG_W-1] ? lep_pkg::TRIG_W'(-b) : lep_pkg::TRIG_W'(b);
      mb_in  = (mb_abs > 32'd1073741824) ? 31'd1073741824 : mb_abs[30:0];
   end

   assign sum = {hi_ff, 16'd0} + 80'(ma_ff[15:0]) * 80'(mb_ff) + 80'd536870912;

   // Upper partial product, then lower partial product and rounding
   always_ff @(posedge clock) begin
      if (reset) begin
         ph1_ff  <= 1'b0;
         ph2_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         ph1_ff  <= start;
         ph2_ff  <= ph1_ff;
         done_ff <= ph2_ff;
      end
      if (start) begin
         ma_ff  <= ma_in;
         mb_ff  <= mb_in;
         neg_ff <= a[lep_pkg::ACC_W-1] ^ b[lep_pkg::TRIG_W-1];
      end
      if (ph1_ff) hi_ff <= 63'(ma_ff[47:16]) * 63'(mb_ff);
      if (ph2_ff) prod_ff <= neg_ff ? -$signed(sum[78:30]) : $signed(sum[78:30]);
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

FILE: rtl/legendre_polynomial_evaluator_unit.sv
// Legendre evaluator top level: sequencer, coefficient ROM and output register.
// Depends on lep_pkg, lep_ifs, lep_cordic and lep_mul.
//
// Usage:
//   req_chan carries func (0 = P_l, 1 = P^1_l), degree l and angle theta
//   (signed Q2.13 radians). rsp_chan returns value (signed Q8.14, saturated)
//   and status (0 ok, 1 degree above 16, 2 P^1 with degree zero).
//   One item is in work at a time; req_chan.ready is high only while idle.
//   Sequence: a request with an error status goes straight to the output
//   state. Otherwise the iterative CORDIC runs first, then each product goes
//   through the shared multiplier (c^2, one per Horner step over x^2, an
//   optional times-cos and, for P^1, times-sin), and rounding follows.
//   The multiplier and the CORDIC loop take most of the time of an item.
//   The coefficient ROM has a registered read, and its address
//   stays put through each multiply.
//   The result sits in an output register; a new request is accepted while it
//   waits, and a finished item waits in its last state if that register is
//   still full because the receiver stalls.
//   Reset (synchronous, active high) empties the block and drops any item.
module legendre_polynomial_evaluator_unit (
   input  logic          clock,
   input  logic          reset,
   lep_req_if.sink       req_chan,
   lep_rsp_if.source     rsp_chan
);
   typedef enum logic [3:0] {
      S_IDLE, S_CSTART, S_CORDIC, S_MUL, S_WAIT, S_NEXT, S_FIN, S_ROUND, S_OUT
   } state_type;

   typedef enum logic [1:0] { MOP_SQ, MOP_LOOP, MOP_C, MOP_S } mop_type;

   state_type                         state_ff;
   mop_type                           mop_ff;
   logic                              func_ff;
   logic [4:0]                        deg_ff;
   logic signed [15:0]                angle_ff;
   logic signed [5:0]                 k_ff;
   logic signed [lep_pkg::ACC_W-1:0]  acc_ff;
   logic signed [lep_pkg::TRIG_W-1:0] cos_ff, sin_ff, x2_ff;
   logic signed [lep_pkg::COEF_W-1:0] coef_ff;
   logic signed [lep_pkg::VALUE_W-1:0] res_value_ff, out_value_ff;
   logic [1:0]                        res_status_ff, out_status_ff;
   logic                              out_valid_ff;
   logic                              out_valid_in;

   logic [lep_pkg::ROM_AW-1:0]        rom_addr;
   logic                              cordic_start, cordic_done;
   logic signed [lep_pkg::TRIG_W-1:0] cordic_cos, cordic_sin;
   logic                              mul_start, mul_done;
   logic signed [lep_pkg::ACC_W-1:0]  mul_a;
   logic signed [lep_pkg::TRIG_W-1:0] mul_b;
   logic signed [lep_pkg::PROD_W-1:0] mul_prod;
   logic signed [45:0]                term;
   logic signed [45:0]                init_p1;
   logic                              loop_more, need_cos, out_free, req_xfer;
   logic [lep_pkg::ACC_W-1:0]         mag;
   logic [38:0]                       q;
   logic signed [lep_pkg::VALUE_W-1:0] round_value;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // Load the output register on a finished item, drop it after its transfer
   assign out_valid_in = (state_ff == S_OUT && out_free) || (out_valid_ff && !rsp_chan.ready);

   // Coefficient ROM with registered read
   assign rom_addr = lep_pkg::ROM_AW'(deg_ff) * lep_pkg::ROM_AW'(lep_pkg::ROW)
                   + lep_pkg::ROM_AW'(k_ff[4:0]);
   always_ff @(posedge clock) begin
      if (rom_addr < lep_pkg::ROM_AW'(lep_pkg::ROM_DEPTH))
         coef_ff <= lep_pkg::COEF_ROM[rom_addr];
      else
         coef_ff <= '0;
   end

   lep_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (angle_ff),
      .done    (cordic_done),
      .cos_out (cordic_cos),
      .sin_out (cordic_sin)
   );

   lep_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign cordic_start = (state_ff == S_CSTART);
   assign mul_start    = (state_ff == S_MUL);

   // Select multiplier operands by pending operation
   always_comb begin
      mul_a = acc_ff;
      mul_b = x2_ff;
      case (mop_ff)
         MOP_SQ: begin
            mul_a = lep_pkg::ACC_W'(cos_ff);
            mul_b = cos_ff;
         end
         MOP_LOOP: mul_b = x2_ff;
         MOP_C:    mul_b = cos_ff;
         MOP_S:    mul_b = sin_ff;
         default:  mul_b = x2_ff;
      endcase
   end

   // Horner terms: plain coefficient, or k times coefficient for the derivative
   assign term    = func_ff ? 46'($signed({1'b0, k_ff[4:0]})) * 46'(coef_ff)
                            : 46'(coef_ff);
   assign init_p1 = 46'($signed({1'b0, deg_ff})) * 46'(coef_ff);
   assign loop_more = func_ff ? (!k_ff[5] && k_ff != 6'sd0) : !k_ff[5];
   assign need_cos  = func_ff ? !deg_ff[0] : deg_ff[0];

   // Round Q24 to Q14 half away from zero, then saturate
   always_comb begin
      mag = acc_ff[lep_pkg::ACC_W-1] ? lep_pkg::ACC_W'(-acc_ff) : lep_pkg::ACC_W'(acc_ff);
      q   = 39'((49'(mag) + 49'd512) >> 10);
      if (acc_ff[lep_pkg::ACC_W-1]) begin
         if (q > 39'd4194304) q = 39'd4194304;
         round_value = -$signed(lep_pkg::VALUE_W'(q));
      end else begin
         if (q > 39'd4194303) q = 39'd4194303;
         round_value = $signed(lep_pkg::VALUE_W'(q));
      end
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mop_ff       <= MOP_SQ;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  func_ff  <= req_chan.func;
                  deg_ff   <= req_chan.degree;
                  angle_ff <= req_chan.angle;
                  k_ff     <= $signed({1'b0, req_chan.degree});
                  res_value_ff <= '0;
                  if (req_chan.func && req_chan.degree == 5'd0) begin
                     res_status_ff <= lep_pkg::STATUS_P1_ZERO;
                     state_ff      <= S_OUT;
                  end else if (req_chan.degree > 5'(lep_pkg::LMAX)) begin
                     res_status_ff <= lep_pkg::STATUS_DEGREE;
                     state_ff      <= S_OUT;
                  end else begin
                     res_status_ff <= lep_pkg::STATUS_OK;
                     state_ff      <= S_CSTART;
                  end
               end
            end
            S_CSTART: state_ff <= S_CORDIC;
            S_CORDIC: begin
               if (cordic_done) begin
                  cos_ff   <= cordic_cos;
                  sin_ff   <= cordic_sin;
                  mop_ff   <= MOP_SQ;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: state_ff <= S_WAIT;
            S_WAIT: begin
               if (mul_done) begin
                  case (mop_ff)
                     MOP_SQ: begin
                        x2_ff    <= lep_pkg::TRIG_W'(mul_prod);
                        acc_ff   <= func_ff ? lep_pkg::sat_acc(50'(init_p1))
                                            : lep_pkg::ACC_W'(coef_ff);
                        k_ff     <= k_ff - 6'sd2;
                        state_ff <= S_NEXT;
                     end
                     MOP_LOOP: begin
                        acc_ff   <= lep_pkg::sat_acc(50'(mul_prod) + 50'(term));
                        k_ff     <= k_ff - 6'sd2;
                        state_ff <= S_NEXT;
                     end
                     MOP_C: begin
                        acc_ff   <= lep_pkg::ACC_W'(mul_prod);
                        state_ff <= S_FIN;
                     end
                     MOP_S: begin
                        acc_ff   <= lep_pkg::sat_acc(-50'(mul_prod));
                        state_ff <= S_ROUND;
                     end
                     default: state_ff <= S_ROUND;
                  endcase
               end
            end
            S_NEXT: begin
               if (loop_more) begin
                  mop_ff   <= MOP_LOOP;
                  state_ff <= S_MUL;
               end else if (need_cos) begin
                  mop_ff   <= MOP_C;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (func_ff) begin
                  mop_ff   <= MOP_S;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               res_value_ff <= round_value;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  out_value_ff  <= res_value_ff;
                  out_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.value = out_value_ff;
   assign rsp_chan.status = out_status_ff;

   // Error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != lep_pkg::STATUS_OK |-> rsp_chan.value == '0)
      else $error("error result with nonzero value");

   // Multiplier completes only while the sequencer waits on it
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_WAIT)
      else $error("multiplier result arrived outside wait state");

   // CORDIC completes only while the sequencer waits on it
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> state_ff == S_CORDIC)
      else $error("cordic result arrived outside wait state");

   // A new transfer into the output register never overwrites a held result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_valid_ff && !rsp_chan.ready |=> state_ff == S_OUT)
      else $error("result left while output register was full");

   // Squared cosine never exceeds one
   a_x2_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NEXT |-> x2_ff >= 0 && x2_ff <= 32'sd1073741824)
      else $error("cos squared out of range");
endmodule

FILE: tb/sv/lep_tb_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Legendre evaluator: predicts each transfer on the request channel.
// Depends on lep_pkg and lep_ifs; compares every response transfer in order.
module lep_tb_checker (
   input  logic  clock,
   input  logic  reset,
   lep_req_if    req_mon,
   lep_rsp_if    rsp_mon,
   output int    fail_count,
   output int    pending_count
);
   typedef struct packed {
      logic signed [22:0] value;
      logic [1:0]         status;
   } lep_result_type;

   longint         coef_table [lep_pkg::ROM_DEPTH];
   lep_result_type expected_results [$];

   localparam longint ACC_MAX  = 64'sd140737488355327;
   localparam longint UNIT_Q30 = 64'sd1073741824;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint COEF_MAX = 64'sd549755813887;
   localparam longint ATAN_Q30 [16] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768
   };

   function automatic longint choose(int a, int b);
      longint r;
      r = 1;
      if (b < 0 || b > a) return 0;
      for (int i = 1; i <= b; i++) r = r * (a - b + i) / i;
      return r;
   endfunction

   // Series term (-1)^m C(n,m) C(2n-2m,n) / 2^n in Q24, clamped to 40 bits
   function automatic longint series_coef(int n, int m);
      logic [127:0] mag;
      mag = 128'(choose(n, m)) * 128'(choose(2*n - 2*m, n));
      mag = mag << (24 - n);
      if (mag > 128'(COEF_MAX)) mag = 128'(COEF_MAX);
      return (m % 2 == 1) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < -ACC_MAX) return -ACC_MAX;
      return v;
   endfunction

   // Q30 product, magnitude rounded half up, second operand clamped to one
   function automatic longint fix_mul(longint a, longint b);
      logic [127:0] ma;
      logic [127:0] mb;
      longint q;
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      if (mb > 128'(UNIT_Q30)) mb = 128'(UNIT_Q30);
      q = longint'((ma * mb + (128'd1 << 29)) >> 30);
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic lep_result_type evaluate(logic f, logic [4:0] deg,
                                               logic signed [15:0] ang);
      lep_result_type res;
      longint th, x, y, z, nx, c, s, x2, acc, mag, q;
      logic flip;
      int d;
      res.value  = '0;
      res.status = lep_pkg::STATUS_OK;
      d = deg;
      if (f && d == 0) begin
         res.status = lep_pkg::STATUS_P1_ZERO;
         return res;
      end
      if (d > lep_pkg::LMAX) begin
         res.status = lep_pkg::STATUS_DEGREE;
         return res;
      end
      // fold into +-pi/2, then rotate
      th = ang;
      flip = 1'b0;
      if (th > 12868) begin th = th - 25736; flip = 1'b1; end
      else if (th < -12868) begin th = th + 25736; flip = 1'b1; end
      x = GAIN_Q30; y = 0; z = th * 131072;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN_Q30[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN_Q30[i];
         end
         x = nx;
      end
      if (x > UNIT_Q30) x = UNIT_Q30;
      if (x < -UNIT_Q30) x = -UNIT_Q30;
      if (y > UNIT_Q30) y = UNIT_Q30;
      if (y < -UNIT_Q30) y = -UNIT_Q30;
      c = flip ? -x : x;
      s = flip ? -y : y;
      x2 = fix_mul(c, c);
      // Horner over x^2
      if (!f) begin
         acc = coef_table[d*lep_pkg::ROW + d];
         for (int k = d - 2; k >= 0; k -= 2)
            acc = clamp_acc(fix_mul(acc, x2) + coef_table[d*lep_pkg::ROW + k]);
         if (d % 2 == 1) acc = fix_mul(acc, c);
      end else begin
         acc = clamp_acc(d * coef_table[d*lep_pkg::ROW + d]);
         for (int k = d - 2; k >= 1; k -= 2)
            acc = clamp_acc(fix_mul(acc, x2) + k * coef_table[d*lep_pkg::ROW + k]);
         if (d % 2 == 0) acc = fix_mul(acc, c);
         acc = -fix_mul(acc, s);
      end
      acc = clamp_acc(acc);
      // Q24 to Q14, round away from zero and saturate
      mag = acc < 0 ? -acc : acc;
      q = (mag + 512) >>> 10;
      if (acc < 0) begin
         if (q > 4194304) q = 4194304;
         res.value = 23'(-q);
      end else begin
         if (q > 4194303) q = 4194303;
         res.value = 23'(q);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      for (int i = 0; i < lep_pkg::ROM_DEPTH; i++) coef_table[i] = 0;
      for (int n = 0; n <= lep_pkg::LMAX; n++)
         for (int m = 0; m <= n / 2; m++)
            coef_table[n*lep_pkg::ROW + n - 2*m] = series_coef(n, m);
   end

   assign pending_count = expected_results.size();

   // Queue each request transfer, check each response transfer
   always @(posedge clock) begin
      lep_result_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(evaluate(req_mon.func, req_mon.degree, req_mon.angle));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_mon.value, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_mon.value !== want.value)
                  report_mismatch("value", rsp_mon.value, want.value);
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
            end
         end
      end
   end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the Legendre evaluator testbench: clock, reset, stimulus and verdict.
// Depends on lep_ifs, the evaluator and lep_tb_checker.
module tb_top;
   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_pct;
   int   stall_pct;
   int   sent_count;

   lep_req_if req_chan ();
   lep_rsp_if rsp_chan ();

   legendre_polynomial_evaluator_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   lep_tb_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // Receiver stalls at random
   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   // Present one request and hold it until the transfer
   task automatic send_item(logic f, logic [4:0] deg, logic signed [15:0] ang);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.func   <= f;
      req_chan.degree <= deg;
      req_chan.angle  <= ang;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_random();
      logic [4:0] deg;
      logic signed [15:0] ang;
      deg = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
      if ($urandom_range(9) == 0) ang = 16'($urandom);
      else ang = 16'($urandom_range(51472) - 25736);
      send_item(1'($urandom), deg, ang);
   endtask

   initial begin
      logic signed [15:0] edge_angles [8];
      int degs [7];
      edge_angles = '{-25736, 25736, 0, 12868, 12869, -12869, 32767, -32768};
      degs = '{0, 1, 2, 15, 16, 17, 31};
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func = 1'b0;
      req_chan.degree = '0;
      req_chan.angle = '0;
      rsp_chan.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      sent_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extreme angles and degrees, both functions
      for (int i = 0; i < 7; i++) begin
         send_item(1'b0, 5'(degs[i]), edge_angles[i]);
         send_item(1'b1, 5'(degs[i]), edge_angles[7 - i]);
      end
      send_item(1'b1, 5'd16, 16'sd32767);
      send_item(1'b0, 5'd16, -16'sd32768);
      send_item(1'b1, 5'd1, 16'sd12868);
      send_item(1'b0, 5'd3, 16'sd1);

      // Random phases with different idling and stalling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         for (int i = 0; i < 475; i++) begin
            if (ph == 2 && i == 200) begin
               // drain before continuing
               req_chan.valid <= 1'b0;
               while (pending_count != 0) @(negedge clock);
            end
            send_random();
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d requests: both functions, degrees 0-31, full angle range,", sent_count);
      $display("under four idle/stall mixes with one full drain.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d results outstanding", pending_count);
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
